### sv/fhw_pkg.sv
// fhw_pkg: shared types, widths and tables of the french hat wavelet scalogram
`timescale 1ns / 1ps
package fhw_pkg;

  localparam int MAX_SCALE = 64;
  localparam int DEPTH     = 3 * MAX_SCALE;
  localparam int SAMPLE_W  = 16;
  localparam int SCALE_W   = 7;
  localparam int POS_W     = 20;
  localparam int ADDR_W    = 8;
  localparam int FILL_W    = 8;
  localparam int ACC_W     = 25;
  localparam int NUM_W     = 27;
  localparam int MAG_W     = 24;
  localparam int DIV_W     = 9;
  localparam int RCP_W     = 30;
  localparam int RCP_SHIFT = 32;
  localparam int QUO_W     = 22;
  localparam int IDX_W     = 2;
  localparam int DATA_W    = 7;

  localparam logic signed [SAMPLE_W-1:0] COEF_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] COEF_MIN = 16'sh8000;

  // register indexes of the configuration port
  typedef enum logic [IDX_W-1:0] {
    REG_MIN_SCALE = 2'd0,
    REG_MAX_SCALE = 2'd1
  } reg_idx_e;

  // one classified sample handed from front to back
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       restart;
    logic [SCALE_W-1:0]         lo;
    logic [SCALE_W-1:0]         hi;
  } job_t;

  // control that travels with one scale step
  typedef struct packed {
    logic [SCALE_W-1:0] scale;
    logic [POS_W-1:0]   position;
    logic               first;
    logic               emit;
    logic               last;
  } ctl_t;

  // one result word
  typedef struct packed {
    logic [SCALE_W-1:0]         scale;
    logic [POS_W-1:0]           position;
    logic signed [SAMPLE_W-1:0] coefficient;
    logic signed [SAMPLE_W-1:0] min_coef;
    logic signed [SAMPLE_W-1:0] max_coef;
    logic                       last;
  } result_t;

  // reciprocals floor(2^32 / (6L)) for L = 1 .. 64
  localparam logic [63:0] RCP_ONE = 64'h1_0000_0000;
  localparam logic [RCP_W-1:0] RECIP [MAX_SCALE] = '{
    RCP_W'(RCP_ONE / 6),   RCP_W'(RCP_ONE / 12),  RCP_W'(RCP_ONE / 18),  RCP_W'(RCP_ONE / 24),
    RCP_W'(RCP_ONE / 30),  RCP_W'(RCP_ONE / 36),  RCP_W'(RCP_ONE / 42),  RCP_W'(RCP_ONE / 48),
    RCP_W'(RCP_ONE / 54),  RCP_W'(RCP_ONE / 60),  RCP_W'(RCP_ONE / 66),  RCP_W'(RCP_ONE / 72),
    RCP_W'(RCP_ONE / 78),  RCP_W'(RCP_ONE / 84),  RCP_W'(RCP_ONE / 90),  RCP_W'(RCP_ONE / 96),
    RCP_W'(RCP_ONE / 102), RCP_W'(RCP_ONE / 108), RCP_W'(RCP_ONE / 114), RCP_W'(RCP_ONE / 120),
    RCP_W'(RCP_ONE / 126), RCP_W'(RCP_ONE / 132), RCP_W'(RCP_ONE / 138), RCP_W'(RCP_ONE / 144),
    RCP_W'(RCP_ONE / 150), RCP_W'(RCP_ONE / 156), RCP_W'(RCP_ONE / 162), RCP_W'(RCP_ONE / 168),
    RCP_W'(RCP_ONE / 174), RCP_W'(RCP_ONE / 180), RCP_W'(RCP_ONE / 186), RCP_W'(RCP_ONE / 192),
    RCP_W'(RCP_ONE / 198), RCP_W'(RCP_ONE / 204), RCP_W'(RCP_ONE / 210), RCP_W'(RCP_ONE / 216),
    RCP_W'(RCP_ONE / 222), RCP_W'(RCP_ONE / 228), RCP_W'(RCP_ONE / 234), RCP_W'(RCP_ONE / 240),
    RCP_W'(RCP_ONE / 246), RCP_W'(RCP_ONE / 252), RCP_W'(RCP_ONE / 258), RCP_W'(RCP_ONE / 264),
    RCP_W'(RCP_ONE / 270), RCP_W'(RCP_ONE / 276), RCP_W'(RCP_ONE / 282), RCP_W'(RCP_ONE / 288),
    RCP_W'(RCP_ONE / 294), RCP_W'(RCP_ONE / 300), RCP_W'(RCP_ONE / 306), RCP_W'(RCP_ONE / 312),
    RCP_W'(RCP_ONE / 318), RCP_W'(RCP_ONE / 324), RCP_W'(RCP_ONE / 330), RCP_W'(RCP_ONE / 336),
    RCP_W'(RCP_ONE / 342), RCP_W'(RCP_ONE / 348), RCP_W'(RCP_ONE / 354), RCP_W'(RCP_ONE / 360),
    RCP_W'(RCP_ONE / 366), RCP_W'(RCP_ONE / 372), RCP_W'(RCP_ONE / 378), RCP_W'(RCP_ONE / 384)
  };

endpackage

### sv/fhw_front.sv
// fhw_front: configuration registers, scale classification and job queue
`timescale 1ns / 1ps
module fhw_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  output logic                             full,
  input  logic signed [fhw_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                             restart_i,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fhw_pkg::IDX_W-1:0]        cfg_index,
  input  logic [fhw_pkg::DATA_W-1:0]       cfg_data,
  output logic                             job_valid_o,
  output fhw_pkg::job_t                    job_o,
  input  logic                             job_ready_i
);
  import fhw_pkg::*;

  localparam int QD = 2;

  logic [SCALE_W-1:0] min_scale_q, max_scale_q;
  logic [SCALE_W-1:0] lo_c, hi_c, lo_d, hi_d;
  job_t               jq_q [QD];
  logic               jq_wp_q, jq_rp_q;
  logic [1:0]         jq_cnt_q;
  logic               in_take, out_take;

  function automatic logic [SCALE_W-1:0] clamp_scale(input logic [SCALE_W-1:0] v);
    logic [SCALE_W-1:0] r;
    r = v;
    if (v == '0) r = SCALE_W'(1);
    else if (v > SCALE_W'(MAX_SCALE)) r = SCALE_W'(MAX_SCALE);
    return r;
  endfunction

  // configuration writes
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_scale_q <= SCALE_W'(1);
      max_scale_q <= SCALE_W'(MAX_SCALE);
    end else if (cfg_valid) begin
      case (reg_idx_e'(cfg_index))
        REG_MIN_SCALE: min_scale_q <= cfg_data;
        REG_MAX_SCALE: max_scale_q <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp and order the scale bounds
  always_comb begin
    lo_c = clamp_scale(min_scale_q);
    hi_c = clamp_scale(max_scale_q);
    lo_d = (lo_c > hi_c) ? hi_c : lo_c;
    hi_d = (lo_c > hi_c) ? lo_c : hi_c;
  end

  // job queue between front and back
  assign full        = (jq_cnt_q == 2'(QD));
  assign in_take     = push_i && !full;
  assign job_valid_o = (jq_cnt_q != '0);
  assign job_o       = jq_q[jq_rp_q];
  assign out_take    = job_valid_o && job_ready_i;

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      jq_q[jq_wp_q] <= '{sample: sample_i, restart: restart_i, lo: lo_d, hi: hi_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jq_wp_q  <= 1'b0;
      jq_rp_q  <= 1'b0;
      jq_cnt_q <= '0;
    end else begin
      if (in_take) jq_wp_q <= ~jq_wp_q;
      if (out_take) jq_rp_q <= ~jq_rp_q;
      jq_cnt_q <= jq_cnt_q + 2'(in_take) - 2'(out_take);
    end
  end

endmodule

### sv/fhw_back.sv
// fhw_back: sample history, scale walk, coefficient divide, extrema and result queue
`timescale 1ns / 1ps
module fhw_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  fhw_pkg::job_t    job_i,
  output logic             job_ready_o,
  input  logic             pop_i,
  output logic             empty_o,
  output fhw_pkg::result_t result_o
);
  import fhw_pkg::*;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW    = 2;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_e;

  // history banks, three copies with two read ports each
  logic signed [SAMPLE_W-1:0] bank0 [DEPTH];
  logic signed [SAMPLE_W-1:0] bank1 [DEPTH];
  logic signed [SAMPLE_W-1:0] bank2 [DEPTH];
  logic signed [SAMPLE_W-1:0] rd_q [6];

  seq_e               state_q;
  logic [5:0]         step_q;
  logic [FILL_W-1:0]  fill_q, fill_base;
  logic [ADDR_W-1:0]  wptr_q, wr_addr, newest_q;
  logic [POS_W-1:0]   idx_q, idx_base, cur_q;
  logic [SCALE_W-1:0] lo_q, hi_q, cur_l;
  logic               adv, pipe_empty, job_take, wr_en;
  logic [ADDR_W-1:0]  ks, k2, k3;
  logic [ADDR_W-1:0]  ra [6];
  logic [8:0]         l3, l3n;
  ctl_t               ctl_d;

  logic               a_vld_q, b_vld_q, c_vld_q, d_vld_q, e_vld_q;
  ctl_t               a_ctl_q, b_ctl_q, c_ctl_q, d_ctl_q, e_ctl_q;
  logic signed [ACC_W-1:0] p1_q, p2_q, p3_q;
  logic signed [NUM_W-1:0] num;
  logic               c_neg_q, d_neg_q, e_neg_q;
  logic [MAG_W-1:0]   c_mag_q, d_mag_q, e_mag_q;
  logic [DIV_W-1:0]   c_div_q, d_div_q, e_div_q;
  logic [53:0]        prod;
  logic [QUO_W-1:0]   d_q0_q, e_q0_q, quo;
  logic [MAG_W-1:0]   e_qd_q, rem;
  logic signed [SAMPLE_W-1:0] coef, min_q, max_q, min_n, max_n;
  logic               rq_push, rq_full, clr_ext;

  result_t            rq_mem [RQ_DEPTH];
  logic [RQ_AW-1:0]   rq_wp_q, rq_rp_q;
  logic [RQ_AW:0]     rq_cnt_q;

  function automatic logic [ADDR_W-1:0] back_addr(input logic [ADDR_W-1:0] nw,
                                                  input logic [ADDR_W-1:0] k);
    logic [ADDR_W:0] t;
    t = (nw >= k) ? ({1'b0, nw} - {1'b0, k}) : ({1'b0, nw} + (ADDR_W+1)'(DEPTH) - {1'b0, k});
    return t[ADDR_W-1:0];
  endfunction

  // whole pipeline advances only while the result queue has room
  assign adv        = !rq_full;
  assign pipe_empty = !a_vld_q && !b_vld_q && !c_vld_q && !d_vld_q && !e_vld_q;
  assign job_ready_o = (state_q == SEQ_IDLE) && adv && pipe_empty;
  assign job_take   = job_valid_i && job_ready_o;
  assign clr_ext    = job_take && job_i.restart;

  // new sample position in history
  assign fill_base = job_i.restart ? '0 : fill_q;
  assign idx_base  = job_i.restart ? '0 : idx_q;
  assign wr_addr   = job_i.restart ? '0 : wptr_q;
  assign wr_en     = job_take;

  // read addresses for one step from scale s to s+1
  always_comb begin
    ks    = ADDR_W'(step_q);
    k2    = {ks[ADDR_W-2:0], 1'b0};
    k3    = k2 + ks;
    ra[0] = back_addr(newest_q, ks);
    ra[1] = back_addr(newest_q, k2);
    ra[2] = back_addr(newest_q, k2 + ADDR_W'(1));
    ra[3] = back_addr(newest_q, k3);
    ra[4] = back_addr(newest_q, k3 + ADDR_W'(1));
    ra[5] = back_addr(newest_q, k3 + ADDR_W'(2));
    cur_l = SCALE_W'(step_q) + SCALE_W'(1);
    l3    = {2'b00, cur_l} + {1'b0, cur_l, 1'b0};
    l3n   = l3 + 9'd3;
    ctl_d.scale    = cur_l;
    ctl_d.position = cur_q + POS_W'(1) - POS_W'(l3);
    ctl_d.first    = (step_q == '0);
    ctl_d.emit     = (cur_l >= lo_q) && (l3 <= {1'b0, fill_q});
    ctl_d.last     = ctl_d.emit && ((cur_l == hi_q) || (l3n > {1'b0, fill_q}));
  end

  // history write and registered reads
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bank0[wr_addr] <= job_i.sample;
      bank1[wr_addr] <= job_i.sample;
      bank2[wr_addr] <= job_i.sample;
    end
    if (adv) begin
      rd_q[0] <= bank0[ra[0]];
      rd_q[1] <= bank0[ra[1]];
      rd_q[2] <= bank1[ra[2]];
      rd_q[3] <= bank1[ra[3]];
      rd_q[4] <= bank2[ra[4]];
      rd_q[5] <= bank2[ra[5]];
    end
  end

  // scale walk sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SEQ_IDLE;
      step_q   <= '0;
      fill_q   <= '0;
      wptr_q   <= '0;
      idx_q    <= '0;
      cur_q    <= '0;
      newest_q <= '0;
      lo_q     <= SCALE_W'(1);
      hi_q     <= SCALE_W'(1);
      a_vld_q  <= 1'b0;
      a_ctl_q  <= '0;
    end else if (adv) begin
      a_vld_q <= 1'b0;
      case (state_q)
        SEQ_IDLE: begin
          if (job_take) begin
            newest_q <= wr_addr;
            wptr_q   <= (wr_addr == ADDR_W'(DEPTH - 1)) ? '0 : wr_addr + ADDR_W'(1);
            fill_q   <= (fill_base == FILL_W'(DEPTH)) ? fill_base : fill_base + FILL_W'(1);
            cur_q    <= idx_base;
            idx_q    <= idx_base + POS_W'(1);
            lo_q     <= job_i.lo;
            hi_q     <= job_i.hi;
            step_q   <= '0;
            state_q  <= SEQ_RUN;
          end
        end
        SEQ_RUN: begin
          a_vld_q <= 1'b1;
          a_ctl_q <= ctl_d;
          if (cur_l == hi_q) state_q <= SEQ_IDLE;
          else step_q <= step_q + 6'd1;
        end
        default: state_q <= SEQ_IDLE;
      endcase
    end
  end

  // running prefix sums P(L), P(2L), P(3L)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && a_vld_q) begin
      b_ctl_q <= a_ctl_q;
      p1_q <= (a_ctl_q.first ? '0 : p1_q) + ACC_W'(rd_q[0]);
      p2_q <= (a_ctl_q.first ? '0 : p2_q) + ACC_W'(rd_q[1]) + ACC_W'(rd_q[2]);
      p3_q <= (a_ctl_q.first ? '0 : p3_q) + ACC_W'(rd_q[3]) + ACC_W'(rd_q[4])
              + ACC_W'(rd_q[5]);
    end
  end

  // numerator 2*middle - first - last = 3*P(2L) - 3*P(L) - P(3L)
  assign num = NUM_W'(3 * NUM_W'(p2_q) - 3 * NUM_W'(p1_q) - NUM_W'(p3_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
      e_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q && b_ctl_q.emit;
      d_vld_q <= c_vld_q;
      e_vld_q <= d_vld_q;
    end
  end

  // reciprocal multiply, then back-multiply for the correction
  assign prod = 54'(c_mag_q) * 54'(RECIP[c_ctl_q.scale[5:0] - 6'd1]);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_ctl_q <= b_ctl_q;
      c_neg_q <= num[NUM_W-1];
      c_mag_q <= MAG_W'(num[NUM_W-1] ? -num : num);
      c_div_q <= {b_ctl_q.scale, 2'b00} + {1'b0, b_ctl_q.scale, 1'b0};
      d_ctl_q <= c_ctl_q;
      d_neg_q <= c_neg_q;
      d_mag_q <= c_mag_q;
      d_div_q <= c_div_q;
      d_q0_q  <= prod[RCP_SHIFT +: QUO_W];
      e_ctl_q <= d_ctl_q;
      e_neg_q <= d_neg_q;
      e_mag_q <= d_mag_q;
      e_div_q <= d_div_q;
      e_q0_q  <= d_q0_q;
      e_qd_q  <= MAG_W'(MAG_W'(d_q0_q) * MAG_W'(d_div_q));
    end
  end

  // correct quotient by one, restore sign, saturate, update extrema
  always_comb begin
    rem = e_mag_q - e_qd_q;
    quo = e_q0_q + QUO_W'(rem >= MAG_W'(e_div_q));
    if (!e_neg_q) coef = (quo > QUO_W'(32767)) ? COEF_MAX : SAMPLE_W'(quo);
    else coef = (quo > QUO_W'(32768)) ? COEF_MIN : -SAMPLE_W'(quo);
    min_n = (coef < min_q) ? coef : min_q;
    max_n = (coef > max_q) ? coef : max_q;
  end

  assign rq_push = e_vld_q && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= COEF_MAX;
      max_q <= COEF_MIN;
    end else if (clr_ext) begin
      min_q <= COEF_MAX;
      max_q <= COEF_MIN;
    end else if (rq_push) begin
      min_q <= min_n;
      max_q <= max_n;
    end
  end

  // result queue
  assign rq_full  = (rq_cnt_q == (RQ_AW+1)'(RQ_DEPTH));
  assign empty_o  = (rq_cnt_q == '0);
  assign result_o = rq_mem[rq_rp_q];

  always_ff @(posedge clk_i) begin
    if (rq_push) begin
      rq_mem[rq_wp_q] <= '{scale: e_ctl_q.scale, position: e_ctl_q.position,
                           coefficient: coef, min_coef: min_n, max_coef: max_n,
                           last: e_ctl_q.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wp_q  <= '0;
      rq_rp_q  <= '0;
      rq_cnt_q <= '0;
    end else begin
      if (rq_push) rq_wp_q <= rq_wp_q + RQ_AW'(1);
      if (pop_i && !empty_o) rq_rp_q <= rq_rp_q + RQ_AW'(1);
      rq_cnt_q <= rq_cnt_q + (RQ_AW+1)'(rq_push) - (RQ_AW+1)'(pop_i && !empty_o);
    end
  end

  // checks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(DEPTH))
    else $error("history fill beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_vld_q |-> (c_ctl_q.scale >= lo_q) && (c_ctl_q.scale <= hi_q))
    else $error("coefficient for scale outside bounds");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_RUN) |-> (SCALE_W'(step_q) < hi_q))
    else $error("scale walk ran past upper bound");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rq_push |-> (min_n <= max_n))
    else $error("running extrema out of order");

endmodule

### sv/french_hat_wavelet_scalogram.sv
// french_hat_wavelet_scalogram: top level joining front, back and ports
`timescale 1ns / 1ps
// Streaming french hat wavelet scalogram. Each pushed sample is written into a
// 192-entry history and then scales 1 up to the upper scale bound are walked one
// per cycle, unless the back end is stalled, through three copies of the history,
// keeping running prefix sums; every scale in range whose window is complete
// yields one word carrying its coefficient (truncated toward zero) and the
// running extrema. In the back end a sample first writes its history entry, then
// takes the scale steps up to the upper scale bound hi, and the divide pipeline
// drains before the next sample starts. The front queue holds two samples
// and the result queue four words; a full result queue stalls the whole back end.
// Scale registers are written through the config channel, which is always ready.
module french_hat_wavelet_scalogram (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic signed [fhw_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                             restart_i,
  output logic                             empty,
  input  logic                             pop,
  output logic [fhw_pkg::SCALE_W-1:0]      scale_o,
  output logic [fhw_pkg::POS_W-1:0]        position_o,
  output logic signed [fhw_pkg::SAMPLE_W-1:0] coefficient_o,
  output logic signed [fhw_pkg::SAMPLE_W-1:0] min_coef_o,
  output logic signed [fhw_pkg::SAMPLE_W-1:0] max_coef_o,
  output logic                             last_o,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fhw_pkg::IDX_W-1:0]        cfg_index,
  input  logic [fhw_pkg::DATA_W-1:0]       cfg_data
);
  import fhw_pkg::*;

  job_t    job;
  logic    job_valid, job_ready;
  result_t res;

  // accept and classify
  fhw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full        (full),
    .sample_i    (sample_i),
    .restart_i   (restart_i),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready)
  );

  // compute and queue results
  fhw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .pop_i       (pop),
    .empty_o     (empty),
    .result_o    (res)
  );

  // result fields
  assign scale_o       = res.scale;
  assign position_o    = res.position;
  assign coefficient_o = res.coefficient;
  assign min_coef_o    = res.min_coef;
  assign max_coef_o    = res.max_coef;
  assign last_o        = res.last;

endmodule
